// ===== hw/rtl/prpa_pkg.sv =====
// Shared types and constants for the push-style PageRank accumulator.
package prpa_pkg;

    localparam int ACTION_W = 2;
    localparam int VTX_W    = 16;
    localparam int DEG_W    = 16;
    localparam int CFG_W    = 17;
    localparam int OUT_W    = 40;
    localparam int STATUS_W = 2;

    // Item kinds carried in s_tuser
    localparam logic [ACTION_W-1:0] ACT_EDGE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ITER = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_INIT = 2'd3;

    // Result status codes carried in m_tuser
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DEGREE = 2'd2;

    localparam int INIT_RANK    = 100000;
    localparam int BASE_RANK    = 15000;
    localparam logic [DEG_W-1:0] DAMP_DIVISOR = 16'd6;
    localparam logic [CFG_W-1:0] VCOUNT_RESET = 17'd65536;

    // Controller to datapath
    typedef struct packed {
        logic latch_item;  // capture the input word
        logic rd_en;       // read both memories
        logic addr_sweep;  // 1: sweep index addresses, 0: item vertices
        logic div_load;    // start the divider
        logic div_sel;     // 0: rank / out-degree, 1: accumulator / 6
        logic acc_we;
        logic acc_wsel;    // 0: clear, 1: saturated sum
        logic rank_we;
        logic rank_wsel;   // 0: initial rank, 1: damped rank
        logic sweep_inc;
        logic sweep_clr;
        logic out_load;
    } prpa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [STATUS_W-1:0] item_status;
        logic                sweep_done;
        logic                div_done;
        logic                out_free;
    } prpa_stat_t;

endpackage

// ===== hw/rtl/prpa_divider.sv =====
// Iterative unsigned divider, four quotient bits per cycle, 16-bit divisor.
module prpa_divider
    import prpa_pkg::*;
#(
    parameter int DW = 40
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [DW-1:0]    dividend,
    input  logic [DEG_W-1:0] divisor,
    output logic             done,
    output logic [DW-1:0]    quotient,
    output logic [DEG_W-1:0] remainder
);

    localparam int BPC   = 4;
    localparam int QW    = ((DW + BPC - 1) / BPC) * BPC;
    localparam int STEPS = QW / BPC;
    localparam int CNTW  = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [QW-1:0]    quo_reg, quo_next;
    logic [DEG_W-1:0] rem_reg, rem_next;
    logic [DEG_W-1:0] dvs_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic             run_reg;
    logic             done_reg;

    // Four restoring steps; remainder stays below the divisor
    always_comb
    begin
        logic [DEG_W:0] trial;
        quo_next = quo_reg;
        rem_next = rem_reg;
        for (int i = 0; i < BPC; i++)
        begin
            trial    = {rem_next, quo_next[QW-1]};
            quo_next = {quo_next[QW-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial       = trial - {1'b0, dvs_reg};
                quo_next[0] = 1'b1;
            end
            rem_next = trial[DEG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (load)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNTW'(STEPS - 1);
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quo_reg <= QW'(dividend);
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg[DW-1:0];
    assign remainder = rem_reg;

endmodule

// ===== hw/rtl/prpa_datapath.sv =====
// Rank and accumulator memories, item registers, arithmetic and output register.
module prpa_datapath
    import prpa_pkg::*;
#(
    parameter int MAX_VERTICES = 65536,
    parameter int RANK_BITS    = 40
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  prpa_cmd_t           cmd,
    output prpa_stat_t          stat,
    input  logic [ACTION_W-1:0] item_action,
    input  logic [VTX_W-1:0]    item_src,
    input  logic [VTX_W-1:0]    item_dst,
    input  logic [DEG_W-1:0]    item_deg,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_W-1:0]    cfg_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,
    output logic [STATUS_W-1:0] m_tuser
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int RB = RANK_BITS;

    function automatic logic [AW-1:0] to_addr(input logic [CFG_W-1:0] v);
        logic [AW+CFG_W-1:0] ext;
        ext = {{AW{1'b0}}, v};
        return ext[AW-1:0];
    endfunction

    logic [RB-1:0] rank_mem [MAX_VERTICES];
    logic [RB-1:0] acc_mem  [MAX_VERTICES];
    logic [RB-1:0] rank_rdata_reg;
    logic [RB-1:0] acc_rdata_reg;

    logic [ACTION_W-1:0] action_reg;
    logic [VTX_W-1:0]    src_reg;
    logic [VTX_W-1:0]    dst_reg;
    logic [DEG_W-1:0]    deg_reg;
    logic [CFG_W-1:0]    vcount_reg;
    logic [CFG_W-1:0]    sweep_reg;
    logic [CFG_W-1:0]    active;
    logic [STATUS_W-1:0] item_status;

    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;
    logic [STATUS_W-1:0] m_tuser_reg;

    logic [AW-1:0]    rank_addr, acc_addr;
    logic [RB-1:0]    div_dividend;
    logic [DEG_W-1:0] div_divisor;
    logic             div_done;
    logic [RB-1:0]    div_q;
    logic [DEG_W-1:0] div_r;

    logic [RB:0]       edge_sum;
    logic [RB-1:0]     acc_sum;
    logic [RB-1:0]     damp_t;
    logic [RB:0]       damp_sum;
    logic [RB-1:0]     damp_rank;
    logic [RB-1:0]     acc_wdata, rank_wdata;
    logic [RB+OUT_W-1:0] rank_ext;

    // Item and configuration registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            action_reg <= item_action;
            src_reg    <= item_src;
            dst_reg    <= item_dst;
            deg_reg    <= item_deg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= VCOUNT_RESET;
        end
        else if (cfg_valid)
        begin
            vcount_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    assign active = (32'(vcount_reg) > MAX_VERTICES) ? CFG_W'(MAX_VERTICES) : vcount_reg;

    always_comb
    begin
        item_status = ST_OK;
        case (action_reg)
            ACT_EDGE:
            begin
                if ({1'b0, src_reg} >= active || {1'b0, dst_reg} >= active)
                    item_status = ST_RANGE;
                else if (deg_reg == '0)
                    item_status = ST_DEGREE;
            end
            ACT_READ:
            begin
                if ({1'b0, src_reg} >= active)
                    item_status = ST_RANGE;
            end
            default:
            begin
                item_status = ST_OK;
            end
        endcase
    end

    // Sweep index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sweep_reg <= '0;
        else if (cmd.sweep_clr)
            sweep_reg <= '0;
        else if (cmd.sweep_inc)
            sweep_reg <= sweep_reg + 1'b1;
    end

    // Memories
    assign rank_addr = cmd.addr_sweep ? to_addr(sweep_reg) : to_addr({1'b0, src_reg});
    assign acc_addr  = cmd.addr_sweep ? to_addr(sweep_reg) : to_addr({1'b0, dst_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.rank_we)
            rank_mem[rank_addr] <= rank_wdata;
        if (cmd.rd_en)
            rank_rdata_reg <= rank_mem[rank_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_we)
            acc_mem[acc_addr] <= acc_wdata;
        if (cmd.rd_en)
            acc_rdata_reg <= acc_mem[acc_addr];
    end

    // Shared divider: rank / out-degree for edges, accumulator / 6 for sweeps
    assign div_dividend = cmd.div_sel ? acc_rdata_reg : rank_rdata_reg;
    assign div_divisor  = cmd.div_sel ? DAMP_DIVISOR : deg_reg;

    prpa_divider #(
        .DW (RB)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (cmd.div_load),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Saturating accumulate
    assign edge_sum = {1'b0, acc_rdata_reg} + {1'b0, div_q};
    assign acc_sum  = edge_sum[RB] ? {RB{1'b1}} : edge_sum[RB-1:0];

    // floor(5a/6) = a - ceil(a/6), then add the base rank with saturation
    assign damp_t    = acc_rdata_reg - div_q - RB'(div_r != '0);
    assign damp_sum  = {1'b0, damp_t} + (RB+1)'(BASE_RANK);
    assign damp_rank = damp_sum[RB] ? {RB{1'b1}} : damp_sum[RB-1:0];

    assign acc_wdata  = cmd.acc_wsel ? acc_sum : '0;
    assign rank_wdata = cmd.rank_wsel ? damp_rank : RB'(INIT_RANK);

    // Output register
    assign rank_ext = {{OUT_W{1'b0}}, rank_rdata_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_tuser_reg <= item_status;
            if (action_reg == ACT_READ && item_status == ST_OK)
                m_tdata_reg <= rank_ext[OUT_W-1:0];
            else
                m_tdata_reg <= '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign stat.action      = action_reg;
    assign stat.item_status = item_status;
    assign stat.sweep_done  = (sweep_reg >= active);
    assign stat.div_done    = div_done;
    assign stat.out_free    = !m_tvalid_reg || m_tready;

endmodule

// ===== hw/rtl/prpa_controller.sv =====
// Sequencing state machine for the PageRank accumulator.
module prpa_controller
    import prpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  prpa_stat_t stat,
    output prpa_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_DISPATCH   = 4'd1;
    localparam logic [3:0] S_EDGE_LOAD  = 4'd2;
    localparam logic [3:0] S_EDGE_DIV   = 4'd3;
    localparam logic [3:0] S_EDGE_WR    = 4'd4;
    localparam logic [3:0] S_SWEEP_RD   = 4'd5;
    localparam logic [3:0] S_SWEEP_LOAD = 4'd6;
    localparam logic [3:0] S_SWEEP_DIV  = 4'd7;
    localparam logic [3:0] S_SWEEP_WR   = 4'd8;
    localparam logic [3:0] S_INIT_WR    = 4'd9;
    localparam logic [3:0] S_FINISH     = 4'd10;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch_item = 1'b1;
                    state_next     = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.rd_en = 1'b1;
                case (stat.action)
                    ACT_EDGE:
                        state_next = (stat.item_status == ST_OK) ? S_EDGE_LOAD : S_FINISH;
                    ACT_ITER:
                        state_next = S_SWEEP_RD;
                    ACT_INIT:
                        state_next = S_INIT_WR;
                    default:
                        state_next = S_FINISH;
                endcase
            end
            S_EDGE_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_EDGE_DIV;
            end
            S_EDGE_DIV:
            begin
                if (stat.div_done)
                    state_next = S_EDGE_WR;
            end
            S_EDGE_WR:
            begin
                cmd.acc_we   = 1'b1;
                cmd.acc_wsel = 1'b1;
                state_next   = S_FINISH;
            end
            S_SWEEP_RD:
            begin
                if (stat.sweep_done)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.rd_en      = 1'b1;
                    cmd.addr_sweep = 1'b1;
                    state_next     = S_SWEEP_LOAD;
                end
            end
            S_SWEEP_LOAD:
            begin
                cmd.div_load = 1'b1;
                cmd.div_sel  = 1'b1;
                state_next   = S_SWEEP_DIV;
            end
            S_SWEEP_DIV:
            begin
                cmd.div_sel = 1'b1;
                if (stat.div_done)
                    state_next = S_SWEEP_WR;
            end
            S_SWEEP_WR:
            begin
                cmd.addr_sweep = 1'b1;
                cmd.acc_we     = 1'b1;
                cmd.rank_we    = 1'b1;
                cmd.rank_wsel  = 1'b1;
                cmd.sweep_inc  = 1'b1;
                state_next     = S_SWEEP_RD;
            end
            S_INIT_WR:
            begin
                if (stat.sweep_done)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.addr_sweep = 1'b1;
                    cmd.acc_we     = 1'b1;
                    cmd.rank_we    = 1'b1;
                    cmd.sweep_inc  = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.sweep_clr = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/pagerank_push_accumulator.sv =====
// Top level of the push-style integer PageRank accumulator.
//
//  channel  direction  signals                      contents (low bit first)
//  s_       in         s_tvalid s_tready            tdata: source_vertex[15:0],
//                      s_tdata[47:0] s_tuser[1:0]   dest_vertex[31:16],
//                                                   source_out_degree[47:32];
//                                                   tuser: action
//  m_       out        m_tvalid m_tready            tdata: rank_value[39:0];
//                      m_tdata[39:0] m_tuser[1:0]   tuser: status
//  cfg_     in         cfg_valid cfg_ready          data: vertex_count[16:0]
//                      cfg_data[16:0]
//
// One item is in work at a time; each item yields exactly one result word.
// Edge items use the shared 4-bit-per-cycle divider (rank / out-degree).
// End-of-iteration items walk every active vertex, the same divider computing
// acc / 6; init items write every active vertex in turn.
// Reset clears control state and sets vertex_count to 65536; the memories
// are not cleared and hold nothing valid until an init item writes them.
// A stalled result sits in the output register while the next item is taken.
module pagerank_push_accumulator
    import prpa_pkg::*;
#(
    parameter int MAX_VERTICES = 65536,
    parameter int RANK_BITS    = 40
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [47:0]         s_tdata,   // source_vertex, dest_vertex, source_out_degree
    input  logic [ACTION_W-1:0] s_tuser,   // action
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,   // rank_value
    output logic [STATUS_W-1:0] m_tuser,   // status
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_W-1:0]    cfg_data   // vertex_count
);

    prpa_cmd_t  cmd;
    prpa_stat_t stat;

    // Sequencer: accept, dispatch on item kind, walk sweeps, hand off result
    prpa_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Memories, divider, saturating arithmetic and the output word register
    prpa_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .RANK_BITS    (RANK_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .item_action (s_tuser),
        .item_src    (s_tdata[15:0]),
        .item_dst    (s_tdata[31:16]),
        .item_deg    (s_tdata[47:32]),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

// ===== hw/rtl/prpa_checker.sv =====
// Port-level checks for the PageRank accumulator, bound to the top level.
module prpa_checker
    import prpa_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OUT_W-1:0]    m_tdata,
    input logic [STATUS_W-1:0] m_tuser
);

    // A stalled result word holds its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // Only the three defined status codes appear
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_RANGE || m_tuser == ST_DEGREE))
        else $error("undefined status code");

    // A flagged item never carries a rank
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
        else $error("flagged result carries a rank");

    // One item in work at a time: input is closed right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

endmodule

bind pagerank_push_accumulator prpa_checker u_prpa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== verif/tb_pagerank_push_accumulator.sv =====
// Self-checking stream testbench for the push-style integer PageRank accumulator.
`timescale 1ns / 1ps

module tb_pagerank_push_accumulator;
    import prpa_pkg::*;

    localparam int MAX_V     = 65536;
    localparam int RANK_BITS = 40;
    localparam logic [RANK_BITS-1:0] RANK_TOP = '1;
    localparam int TAIL_CYCLES = 100;

    // One input word as the generator builds it, and one expected result word.
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [VTX_W-1:0]    src;
        logic [VTX_W-1:0]    dst;
        logic [DEG_W-1:0]    deg;
    } rank_job_t;

    typedef struct packed {
        logic [OUT_W-1:0]    rank;
        logic [STATUS_W-1:0] status;
    } rank_reply_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [47:0]         s_tdata   = '0;       // source_vertex, dest_vertex, source_out_degree
    logic [ACTION_W-1:0] s_tuser   = ACT_EDGE; // action
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [OUT_W-1:0]    m_tdata;              // rank_value
    logic [STATUS_W-1:0] m_tuser;              // status
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data  = '0;       // vertex_count

    pagerank_push_accumulator #(
        .MAX_VERTICES (MAX_V),
        .RANK_BITS    (RANK_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Rank predictor: own copy of both memories and of vertex_count
    // ------------------------------------------------------------------
    logic [RANK_BITS-1:0] rank_mem [MAX_V];
    logic [RANK_BITS-1:0] acc_mem  [MAX_V];
    logic [CFG_W-1:0]     vcount_shadow = VCOUNT_RESET;

    // counts above the memory depth clamp to the depth
    function automatic int live_count(input logic [CFG_W-1:0] v);
        return (v > MAX_V) ? MAX_V : int'(v);
    endfunction

    function automatic logic [RANK_BITS-1:0] sat_sum(input logic [RANK_BITS-1:0] a,
                                                     input logic [RANK_BITS-1:0] b);
        logic [RANK_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[RANK_BITS] ? RANK_TOP : s[RANK_BITS-1:0];
    endfunction

    // 15000 + floor(5*acc/6), split so the product never overflows
    function automatic logic [RANK_BITS-1:0] damped_rank(input logic [RANK_BITS-1:0] acc);
        longint unsigned a;
        longint unsigned t;
        a = acc;
        t = 5 * (a / 6) + (5 * (a % 6)) / 6;
        if (t > RANK_TOP)
            t = RANK_TOP;
        t = t + BASE_RANK;
        if (t > RANK_TOP)
            t = RANK_TOP;
        return t[RANK_BITS-1:0];
    endfunction

    function automatic rank_reply_t rank_step(input rank_job_t job);
        rank_reply_t r;
        int n;
        n = live_count(vcount_shadow);
        r.rank   = '0;
        r.status = ST_OK;
        case (job.action)
            ACT_EDGE:
            begin
                // range check wins over the out-degree check
                if (job.src >= n || job.dst >= n)
                    r.status = ST_RANGE;
                else if (job.deg == '0)
                    r.status = ST_DEGREE;
                else
                    acc_mem[job.dst] = sat_sum(acc_mem[job.dst], rank_mem[job.src] / job.deg);
            end
            ACT_ITER:
            begin
                for (int v = 0; v < n; v++)
                begin
                    rank_mem[v] = damped_rank(acc_mem[v]);
                    acc_mem[v]  = '0;
                end
            end
            ACT_READ:
            begin
                if (job.src >= n)
                    r.status = ST_RANGE;
                else
                    r.rank = rank_mem[job.src];
            end
            default:
            begin
                for (int v = 0; v < n; v++)
                begin
                    rank_mem[v] = INIT_RANK;
                    acc_mem[v]  = '0;
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input side: driver fed from jobs_waiting, prediction at acceptance
    // ------------------------------------------------------------------
    rank_job_t   jobs_waiting [$];
    rank_reply_t replies_due  [$];
    rank_job_t   bus_job;
    rank_reply_t due;
    logic        word_taken = 1'b0;
    int          in_idle    = 0;
    int          out_idle   = 0;
    int          error_count = 0;
    bit          calm    = 1'b0;   // phase without any idling
    bit          no_idle = 1'b0;   // last part of the run

    always @(posedge clk)
    begin
        word_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            bus_job.action = s_tuser;
            bus_job.src    = s_tdata[15:0];
            bus_job.dst    = s_tdata[31:16];
            bus_job.deg    = s_tdata[47:32];
            replies_due.push_back(rank_step(bus_job));
        end
    end

    // A word stays on the bus until taken; gaps only fall between words.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || word_taken))
        begin
            if (in_idle > 0)
            begin
                in_idle--;
                s_tvalid <= 1'b0;
            end
            else if (jobs_waiting.size() == 0)
                s_tvalid <= 1'b0;
            else if (!no_idle && !calm && $urandom_range(0, 4) == 0)
            begin
                in_idle = $urandom_range(0, 2);
                s_tvalid <= 1'b0;
            end
            else
            begin
                bus_job = jobs_waiting.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {bus_job.deg, bus_job.dst, bus_job.src};
                s_tuser  <= bus_job.action;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: random back-pressure and field-by-field compare
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (out_idle > 0)
        begin
            out_idle--;
            m_tready <= 1'b0;
        end
        else if (!no_idle && !calm && $urandom_range(0, 4) == 0)
        begin
            out_idle = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic log_error(input string msg);
        error_count++;
        if (error_count <= 100)
            $display("ERROR: %s", msg);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (replies_due.size() == 0)
                log_error($sformatf("result word with nothing outstanding: rank %h status %h",
                                    m_tdata, m_tuser));
            else
            begin
                due = replies_due.pop_front();
                if (m_tdata !== due.rank)
                    log_error($sformatf("rank_value got %h want %h", m_tdata, due.rank));
                if (m_tuser !== due.status)
                    log_error($sformatf("status got %h want %h", m_tuser, due.status));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    int jobs_queued = 0;
    int gen_live    = MAX_V;   // active count the stimulus is built for
    int gen_written = 0;       // entries below this were set by an init word
    int sweeps_left = 0;       // caps sweeps where the active set is large
    logic [ACTION_W-1:0] all_acts [4] = '{ACT_EDGE, ACT_ITER, ACT_READ, ACT_INIT};

    task automatic queue_job(input logic [ACTION_W-1:0] a, input int s, input int d, input int g);
        rank_job_t j;
        j.action = a;
        j.src    = s[VTX_W-1:0];
        j.dst    = d[VTX_W-1:0];
        j.deg    = g[DEG_W-1:0];
        jobs_waiting.push_back(j);
        jobs_queued++;
        if (a == ACT_ITER || a == ACT_INIT)
            sweeps_left--;
        if (a == ACT_INIT && gen_live > gen_written)
            gen_written = gen_live;
    endtask

    // Mostly well-formed pushes/reads/sweeps over written vertices, some noise.
    // In-range vertices always sit below gen_written, so no unwritten entry is read.
    task automatic queue_random_job(input bit allow_sweep);
        int  pick;
        int  n;
        int  far;
        bit  sweep_ok;
        logic [ACTION_W-1:0] noise_act;
        n = gen_live;
        pick = $urandom_range(0, 99);
        sweep_ok = allow_sweep && sweeps_left > 0;
        noise_act = sweep_ok ? all_acts[$urandom_range(0, 3)]
                             : all_acts[2 * $urandom_range(0, 1)];
        if (n == 0)
            queue_job(all_acts[$urandom_range(0, 3)], $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535));
        else if (pick < 50)
            queue_job(ACT_EDGE, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                  : $urandom_range(1, 6));
        else if (pick < 65)
            queue_job(ACT_READ, $urandom_range(0, n - 1), $urandom_range(0, 65535),
                      $urandom_range(0, 65535));
        else if (pick < 73 && sweep_ok)
            queue_job(ACT_ITER, $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535));
        else if (pick < 75 && sweep_ok)
            queue_job(ACT_INIT, $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535));
        else if (pick < 82)
            queue_job(ACT_EDGE, $urandom_range(0, n - 1), $urandom_range(0, n - 1), 0);
        else if (pick < 92 && n < MAX_V)
        begin
            far = $urandom_range(n, 65535);
            case ($urandom_range(0, 2))
                0: queue_job(ACT_EDGE, far, $urandom_range(0, n - 1), $urandom_range(0, 65535));
                1: queue_job(ACT_EDGE, $urandom_range(0, n - 1), far, $urandom_range(0, 65535));
                default: queue_job(ACT_READ, far, $urandom_range(0, 65535), 0);
            endcase
        end
        else
            queue_job(noise_act, $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535));
    endtask

    // Holds the sender until every word sent so far has its result back.
    task automatic drain_replies();
        do
            @(posedge clk);
        while (jobs_waiting.size() != 0 || s_tvalid || replies_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_vertex_count(input logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        vcount_shadow = v;
        gen_live = live_count(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] v, input int n_jobs);
        drain_replies();
        set_vertex_count(v);
        calm = ($urandom_range(0, 3) == 0);
        sweeps_left = (gen_live > 256) ? 2 : 1000;
        if (gen_live > gen_written)
            queue_job(ACT_INIT, 0, 0, 0);
        repeat (n_jobs) queue_random_job(gen_live <= 1024);
    endtask

    initial
    begin
        int p;
        int r;
        logic [CFG_W-1:0] v;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: four vertices, every action, range and degree corner cases
        drain_replies();
        set_vertex_count(17'd4);
        queue_job(ACT_INIT, 0, 0, 0);
        queue_job(ACT_READ, 0, 0, 0);
        queue_job(ACT_READ, 3, 0, 0);
        queue_job(ACT_READ, 4, 0, 0);
        queue_job(ACT_READ, 65535, 0, 0);
        queue_job(ACT_EDGE, 0, 1, 1);
        queue_job(ACT_EDGE, 3, 0, 65535);
        queue_job(ACT_EDGE, 0, 4, 0);        // out of range beats zero degree
        queue_job(ACT_EDGE, 4, 0, 3);
        queue_job(ACT_EDGE, 1, 2, 0);
        queue_job(ACT_EDGE, 2, 2, 3);
        queue_job(ACT_EDGE, 1, 3, 7);
        queue_job(ACT_ITER, 0, 0, 0);
        for (int i = 0; i < 4; i++)
            queue_job(ACT_READ, i, 0, 0);

        // no active vertex: everything is out of range, sweeps touch nothing
        drain_replies();
        set_vertex_count(17'd0);
        queue_job(ACT_READ, 0, 0, 0);
        queue_job(ACT_EDGE, 0, 0, 1);
        queue_job(ACT_ITER, 0, 0, 0);
        queue_job(ACT_INIT, 0, 0, 0);

        // Single vertex pushing to itself: ranks grow until the sums saturate
        drain_replies();
        set_vertex_count(17'd1);
        queue_job(ACT_INIT, 0, 0, 0);
        repeat (8)
        begin
            repeat (20) queue_job(ACT_EDGE, 0, 0, 1);
            queue_job(ACT_ITER, 0, 0, 0);
            queue_job(ACT_READ, 0, 0, 0);
        end

        // Full memory depth, then a count above it
        run_phase(17'd65536, 20);
        queue_job(ACT_READ, 65535, 0, 0);
        queue_job(ACT_EDGE, 65535, 0, 1);
        queue_job(ACT_EDGE, 0, 65535, 2);
        queue_job(ACT_EDGE, 40000, 32768, 65535);
        queue_job(ACT_READ, 32768, 0, 0);
        run_phase(17'h1FFFF, 20);

        p = 0;
        while (jobs_queued < 900)
        begin
            r = $urandom_range(0, 9);
            if (p == 1)
                v = 17'd1024;
            else if (r == 0)
                v = 17'd0;
            else if (r <= 2)
                v = $urandom_range(17, 200);
            else if (r == 3)
                v = 17'd1;
            else
                v = $urandom_range(2, 16);
            run_phase(v, $urandom_range(30, 70));
            p++;
        end

        // closing stretch with both sides always ready
        drain_replies();
        no_idle = 1'b1;
        run_phase($urandom_range(2, 16), 50);

        drain_replies();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("pagerank_push_accumulator test passed");
        else
            $display("pagerank_push_accumulator test failed");
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial
    begin
        #24_000_000;
        $display("pagerank_push_accumulator test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/prpa_pkg.sv
hw/rtl/prpa_divider.sv
hw/rtl/prpa_datapath.sv
hw/rtl/prpa_controller.sv
hw/rtl/pagerank_push_accumulator.sv
hw/rtl/prpa_checker.sv
verif/tb_pagerank_push_accumulator.sv
